// ===== rtl/rbsi_pkg.sv =====
package rbsi_pkg;

	// Number of axes handled in parallel.
	localparam int unsigned AXES = 3;

	// Reciprocal divider layout: quotient bits resolved per stage, and stage count.
	localparam int unsigned DIV_BITS   = 2;
	localparam int unsigned DIV_STAGES = 32 / DIV_BITS;

	// Smallest Q16.16 distance that counts as a hit (just above 1e-4).
	localparam logic signed [31:0] T_THRESHOLD = 32'sd7;

	// Saturation limits of the signed Q16.16 range.
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// Normal component codes.
	localparam logic [1:0] NRM_POS  = 2'b01;
	localparam logic [1:0] NRM_NEG  = 2'b11;
	localparam logic [1:0] NRM_ZERO = 2'b00;

	// One input item: ray origin, direction and box corners, per axis.
	typedef struct packed {
		logic [AXES-1:0][31:0] org;
		logic [AXES-1:0][31:0] dir;
		logic [AXES-1:0][31:0] lo;
		logic [AXES-1:0][31:0] hi;
	} item_t;

	// One result item.
	typedef struct packed {
		logic                  hit;
		logic [31:0]           hdist;
		logic [AXES-1:0][31:0] pos;
		logic [AXES-1:0][1:0]  nrm;
	} res_t;

	// Saturate a 49-bit signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
		logic signed [48:0] vmax;
		logic signed [48:0] vmin;
		vmax = 49'(Q_MAX);
		vmin = 49'(Q_MIN);
		if (v > vmax) begin
			return Q_MAX;
		end else if (v < vmin) begin
			return Q_MIN;
		end
		return v[31:0];
	endfunction

endpackage

// ===== rtl/ray_box_slab_intersect_core.sv =====
// Each accepted item yields one result.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// The 16 reciprocal stages (two quotient bits each) set most of the latency.
// Reset clears all valid bits; no item is in flight after arst_n is released.
module ray_box_slab_intersect_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_min_x, box_min_y,
	// box_min_z, box_max_x, box_max_y, box_max_z (32 bits each)
	input  logic [383:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit_found, hit_dist, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, one pad bit
	output logic [135:0] m_tdata
);

	localparam int unsigned NA = rbsi_pkg::AXES;

	logic                adv;
	rbsi_pkg::item_t     item_in;
	logic                rc_valid;
	rbsi_pkg::item_t     rc_item;
	logic [NA-1:0][31:0] rc_inv;
	logic                sl_valid;
	rbsi_pkg::item_t     sl_item;
	logic [NA-1:0][33:0] sl_ctr, sl_hc;
	logic                sl_hit;
	logic [31:0]         sl_t;
	rbsi_pkg::res_t      res;

	// The pipeline moves whenever the output register is free or being taken.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Unpack the input item.
	always_comb begin
		for (int l = 0; l < int'(NA); l++) begin
			item_in.org[l] = s_tdata[32*l      +: 32];
			item_in.dir[l] = s_tdata[32*(l+3)  +: 32];
			item_in.lo[l]  = s_tdata[32*(l+6)  +: 32];
			item_in.hi[l]  = s_tdata[32*(l+9)  +: 32];
		end
	end

	rbsi_recip u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (s_tvalid),
		.in_item  (item_in),
		.out_valid(rc_valid),
		.out_item (rc_item),
		.out_inv  (rc_inv)
	);

	rbsi_slab u_slab (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (rc_valid),
		.in_item  (rc_item),
		.in_inv   (rc_inv),
		.out_valid(sl_valid),
		.out_item (sl_item),
		.out_ctr  (sl_ctr),
		.out_hc   (sl_hc),
		.out_hit  (sl_hit),
		.out_t    (sl_t)
	);

	rbsi_hit u_hit (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (sl_valid),
		.in_item  (sl_item),
		.in_ctr   (sl_ctr),
		.in_hc    (sl_hc),
		.in_hit   (sl_hit),
		.in_t     (sl_t),
		.out_valid(m_tvalid),
		.out_res  (res)
	);

	// Pack the result item.
	assign m_tdata = {1'b0, res.nrm[2], res.nrm[1], res.nrm[0], res.pos[2], res.pos[1],
		res.pos[0], res.hdist, res.hit};

`ifndef ASSERT_OFF
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[135:1] == 135'd0)
		else $error("miss result carries nonzero fields");
	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> $signed(m_tdata[32:1]) >= rbsi_pkg::T_THRESHOLD)
		else $error("hit distance below threshold");
	a_one_normal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |->
		$countones({|m_tdata[134:133], |m_tdata[132:131], |m_tdata[130:129]}) == 1)
		else $error("hit normal does not have exactly one axis");
`endif

endmodule

// ===== rtl/rbsi_recip.sv =====
module rbsi_recip (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  rbsi_pkg::item_t                      in_item,
	output logic                                 out_valid,
	output rbsi_pkg::item_t                      out_item,
	output logic [rbsi_pkg::AXES-1:0][31:0]      out_inv
);

	localparam int unsigned NS = rbsi_pkg::DIV_STAGES;
	localparam int unsigned NA = rbsi_pkg::AXES;

	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] quo;
	} div_t;

	// DIV_BITS restoring division steps of 2^32 / magnitude.
	function automatic div_t div_step(input div_t cur, input logic [31:0] dv);
		div_t        r;
		logic [32:0] sh;
		r = cur;
		for (int i = 0; i < int'(rbsi_pkg::DIV_BITS); i++) begin
			sh = {r.rem[31:0], 1'b0};
			if (sh >= {1'b0, dv}) begin
				r.rem = sh - {1'b0, dv};
				r.quo = {r.quo[30:0], 1'b1};
			end else begin
				r.rem = sh;
				r.quo = {r.quo[30:0], 1'b0};
			end
		end
		return r;
	endfunction

	logic                      vld_s  [NS+1];
	rbsi_pkg::item_t           item_s [NS+1];
	logic [NA-1:0][31:0]       dv_s   [NS+1];
	div_t [NA-1:0]             dq_s   [NS+1];
	logic [NA-1:0]             neg_s  [NS+1];
	logic [NA-1:0]             satp_s [NS+1];
	logic [NA-1:0]             satn_s [NS+1];

	// Entry stage: magnitude of each direction and the saturating cases.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s[0] <= in_item;
			for (int l = 0; l < int'(NA); l++) begin
				dv_s[0][l]     <= in_item.dir[l][31] ? (~in_item.dir[l] + 32'd1) : in_item.dir[l];
				dq_s[0][l].rem <= 33'd1;
				dq_s[0][l].quo <= 32'd0;
				neg_s[0][l]    <= in_item.dir[l][31];
				satp_s[0][l]   <= (in_item.dir[l] == 32'd0) || (in_item.dir[l] == 32'd1)
					|| (in_item.dir[l] == 32'd2);
				satn_s[0][l]   <= (in_item.dir[l] == 32'hffff_ffff)
					|| (in_item.dir[l] == 32'hffff_fffe);
			end
		end
	end

	// Division stages.
	for (genvar g = 1; g <= NS; g++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_s[g] <= item_s[g-1];
				dv_s[g]   <= dv_s[g-1];
				neg_s[g]  <= neg_s[g-1];
				satp_s[g] <= satp_s[g-1];
				satn_s[g] <= satn_s[g-1];
				for (int l = 0; l < int'(NA); l++) begin
					dq_s[g][l] <= div_step(dq_s[g-1][l], dv_s[g-1][l]);
				end
			end
		end
	end

	// Apply sign and saturation to the quotient.
	always_comb begin
		for (int l = 0; l < int'(NA); l++) begin
			if (satp_s[NS][l]) begin
				out_inv[l] = rbsi_pkg::Q_MAX;
			end else if (satn_s[NS][l]) begin
				out_inv[l] = rbsi_pkg::Q_MIN;
			end else if (neg_s[NS][l]) begin
				out_inv[l] = ~dq_s[NS][l].quo + 32'd1;
			end else begin
				out_inv[l] = dq_s[NS][l].quo;
			end
		end
	end

	assign out_valid = vld_s[NS];
	assign out_item  = item_s[NS];

endmodule

// ===== rtl/rbsi_slab.sv =====
module rbsi_slab (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  rbsi_pkg::item_t                      in_item,
	input  logic [rbsi_pkg::AXES-1:0][31:0]      in_inv,
	output logic                                 out_valid,
	output rbsi_pkg::item_t                      out_item,
	output logic [rbsi_pkg::AXES-1:0][33:0]      out_ctr,
	output logic [rbsi_pkg::AXES-1:0][33:0]      out_hc,
	output logic                                 out_hit,
	output logic [31:0]                          out_t
);

	localparam int unsigned NA = rbsi_pkg::AXES;

	logic                vld_sa, vld_sb, vld_sc, vld_sd, vld_se, vld_sf;
	rbsi_pkg::item_t     item_sa, item_sb, item_sc, item_sd, item_se, item_sf;
	logic [NA-1:0][33:0] ctr_sa, ctr_sb, ctr_sc, ctr_sd, ctr_se, ctr_sf;
	logic [NA-1:0][33:0] hc_sa, hc_sb, hc_sc, hc_sd, hc_se, hc_sf;
	logic [NA-1:0][32:0] dn_sa, df_sa;
	logic [NA-1:0][31:0] inv_sa;
	logic [NA-1:0][64:0] pn_sb, pf_sb;
	logic [NA-1:0][31:0] a_sc, b_sc;
	logic [31:0]         tmin_sd, tmax_sd, a2_sd, b2_sd;
	logic                ok_sd;
	logic [31:0]         tmin_se, tmax_se;
	logic                ok_se;
	logic                hit_sf;
	logic [31:0]         t_sf;

	// Valid bits advance with the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
			vld_sb <= 1'b0;
			vld_sc <= 1'b0;
			vld_sd <= 1'b0;
			vld_se <= 1'b0;
			vld_sf <= 1'b0;
		end else if (en) begin
			vld_sa <= in_valid;
			vld_sb <= vld_sa;
			vld_sc <= vld_sb;
			vld_sd <= vld_sc;
			vld_se <= vld_sd;
			vld_sf <= vld_se;
		end
	end

	// Stage A: corner offsets from the origin, box center and half extent.
	always_ff @(posedge clk) begin
		logic signed [32:0] nc, fc, og, span;
		logic signed [33:0] ctr;
		if (en) begin
			item_sa <= in_item;
			inv_sa  <= in_inv;
			for (int l = 0; l < int'(NA); l++) begin
				og   = 33'($signed(in_item.org[l]));
				nc   = in_inv[l][31] ? 33'($signed(in_item.hi[l])) : 33'($signed(in_item.lo[l]));
				fc   = in_inv[l][31] ? 33'($signed(in_item.lo[l])) : 33'($signed(in_item.hi[l]));
				span = 33'($signed(in_item.hi[l])) - 33'($signed(in_item.lo[l]));
				ctr  = 34'($signed(in_item.lo[l])) + 34'(span >>> 1);
				dn_sa[l]  <= nc - og;
				df_sa[l]  <= fc - og;
				ctr_sa[l] <= ctr;
				hc_sa[l]  <= 34'($signed(in_item.hi[l])) - ctr;
			end
		end
	end

	// Stage B: offsets times reciprocal.
	always_ff @(posedge clk) begin
		if (en) begin
			item_sb <= item_sa;
			ctr_sb  <= ctr_sa;
			hc_sb   <= hc_sa;
			for (int l = 0; l < int'(NA); l++) begin
				pn_sb[l] <= 65'($signed(dn_sa[l]) * $signed(inv_sa[l]));
				pf_sb[l] <= 65'($signed(df_sa[l]) * $signed(inv_sa[l]));
			end
		end
	end

	// Stage C: drop fraction bits toward minus infinity and saturate.
	always_ff @(posedge clk) begin
		if (en) begin
			item_sc <= item_sb;
			ctr_sc  <= ctr_sb;
			hc_sc   <= hc_sb;
			for (int l = 0; l < int'(NA); l++) begin
				a_sc[l] <= rbsi_pkg::sat49($signed(pn_sb[l][64:16]));
				b_sc[l] <= rbsi_pkg::sat49($signed(pf_sb[l][64:16]));
			end
		end
	end

	// Stage D: merge the x and y slabs.
	always_ff @(posedge clk) begin
		if (en) begin
			item_sd <= item_sc;
			ctr_sd  <= ctr_sc;
			hc_sd   <= hc_sc;
			a2_sd   <= a_sc[2];
			b2_sd   <= b_sc[2];
			ok_sd   <= !(($signed(a_sc[0]) > $signed(b_sc[1]))
				|| ($signed(a_sc[1]) > $signed(b_sc[0])));
			tmin_sd <= ($signed(a_sc[1]) > $signed(a_sc[0])) ? a_sc[1] : a_sc[0];
			tmax_sd <= ($signed(b_sc[1]) < $signed(b_sc[0])) ? b_sc[1] : b_sc[0];
		end
	end

	// Stage E: merge the z slab.
	always_ff @(posedge clk) begin
		if (en) begin
			item_se <= item_sd;
			ctr_se  <= ctr_sd;
			hc_se   <= hc_sd;
			ok_se   <= ok_sd && !(($signed(tmin_sd) > $signed(b2_sd))
				|| ($signed(a2_sd) > $signed(tmax_sd)));
			tmin_se <= ($signed(a2_sd) > $signed(tmin_sd)) ? a2_sd : tmin_sd;
			tmax_se <= ($signed(b2_sd) < $signed(tmax_sd)) ? b2_sd : tmax_sd;
		end
	end

	// Stage F: pick entry or exit distance and test the threshold.
	always_ff @(posedge clk) begin
		logic [31:0] t;
		if (en) begin
			t = ($signed(tmin_se) < rbsi_pkg::T_THRESHOLD) ? tmax_se : tmin_se;
			item_sf <= item_se;
			ctr_sf  <= ctr_se;
			hc_sf   <= hc_se;
			t_sf    <= t;
			hit_sf  <= ok_se && ($signed(t) >= rbsi_pkg::T_THRESHOLD);
		end
	end

	assign out_valid = vld_sf;
	assign out_item  = item_sf;
	assign out_ctr   = ctr_sf;
	assign out_hc    = hc_sf;
	assign out_hit   = hit_sf;
	assign out_t     = t_sf;

endmodule

// ===== rtl/rbsi_hit.sv =====
module rbsi_hit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  rbsi_pkg::item_t                      in_item,
	input  logic [rbsi_pkg::AXES-1:0][33:0]      in_ctr,
	input  logic [rbsi_pkg::AXES-1:0][33:0]      in_hc,
	input  logic                                 in_hit,
	input  logic [31:0]                          in_t,
	output logic                                 out_valid,
	output rbsi_pkg::res_t                       out_res
);

	localparam int unsigned NA = rbsi_pkg::AXES;

	logic                vld_sg, vld_sh, vld_si, vld_sj;
	logic [NA-1:0][63:0] prod_sg;
	logic [NA-1:0][31:0] org_sg;
	logic [NA-1:0][33:0] ctr_sg, ctr_sh, hc_sg, hc_sh;
	logic                hit_sg, hit_sh, hit_si;
	logic [31:0]         t_sg, t_sh, t_si;
	logic [NA-1:0][31:0] pos_sh, pos_si;
	logic [NA-1:0][35:0] fd_si;
	logic [NA-1:0]       nl_si;
	rbsi_pkg::res_t      res_sj;

	// Valid bits advance with the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sg <= 1'b0;
			vld_sh <= 1'b0;
			vld_si <= 1'b0;
			vld_sj <= 1'b0;
		end else if (en) begin
			vld_sg <= in_valid;
			vld_sh <= vld_sg;
			vld_si <= vld_sh;
			vld_sj <= vld_si;
		end
	end

	// Stage G: direction times distance.
	always_ff @(posedge clk) begin
		if (en) begin
			hit_sg <= in_hit;
			t_sg   <= in_t;
			ctr_sg <= in_ctr;
			hc_sg  <= in_hc;
			org_sg <= in_item.org;
			for (int l = 0; l < int'(NA); l++) begin
				prod_sg[l] <= $signed(in_item.dir[l]) * $signed(in_t);
			end
		end
	end

	// Stage H: hit point with saturation.
	always_ff @(posedge clk) begin
		if (en) begin
			hit_sh <= hit_sg;
			t_sh   <= t_sg;
			ctr_sh <= ctr_sg;
			hc_sh  <= hc_sg;
			for (int l = 0; l < int'(NA); l++) begin
				pos_sh[l] <= rbsi_pkg::sat49(49'($signed(org_sg[l]))
					+ 49'($signed(prod_sg[l][63:16])));
			end
		end
	end

	// Stage I: distance of the hit point to the nearest face of each slab.
	always_ff @(posedge clk) begin
		logic signed [35:0] loc, aloc, dd;
		if (en) begin
			hit_si <= hit_sh;
			t_si   <= t_sh;
			pos_si <= pos_sh;
			for (int l = 0; l < int'(NA); l++) begin
				loc  = 36'($signed(pos_sh[l])) - 36'($signed(ctr_sh[l]));
				aloc = loc[35] ? -loc : loc;
				dd   = 36'($signed(hc_sh[l])) - aloc;
				fd_si[l] <= dd[35] ? 36'(-dd) : 36'(dd);
				nl_si[l] <= loc[35];
			end
		end
	end

	// Stage J: choose the face axis and form the result.
	always_ff @(posedge clk) begin
		logic [35:0] best;
		logic [1:0]  sel;
		if (en) begin
			best = fd_si[0];
			sel  = 2'd0;
			for (int l = 1; l < int'(NA); l++) begin
				if (fd_si[l] < best) begin
					best = fd_si[l];
					sel  = 2'(l);
				end
			end
			res_sj.hit   <= hit_si;
			res_sj.hdist <= hit_si ? t_si : 32'd0;
			for (int l = 0; l < int'(NA); l++) begin
				res_sj.pos[l] <= hit_si ? pos_si[l] : 32'd0;
				if (hit_si && (sel == 2'(l))) begin
					res_sj.nrm[l] <= nl_si[l] ? rbsi_pkg::NRM_POS : rbsi_pkg::NRM_NEG;
				end else begin
					res_sj.nrm[l] <= rbsi_pkg::NRM_ZERO;
				end
			end
		end
	end

	assign out_valid = vld_sj;
	assign out_res   = res_sj;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned LATENCY   = 27;
	localparam int unsigned N_RANDOM  = 1600;
	localparam longint      CYCLE_CAP = 400000;

	// Output field widths, lowest bit first.
	typedef struct {
		bit              hit;
		bit [31:0]       hdist;
		bit [2:0][31:0]  pos;
		bit [2:0][1:0]   nrm;
	} ray_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [383:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;

	bit [383:0]  pending_rays[$];
	ray_result_t expected_hits[$];
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned error_count;
	int unsigned results_seen;
	int unsigned hits_seen;
	longint      cycle_count;

	ray_box_slab_intersect_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Floor of a product divided by 65536.
	function automatic longint shr16_floor(input longint p);
		return p >>> 16;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint to_long(input bit [31:0] raw);
		return longint'(signed'(raw));
	endfunction

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Slab test on one ray item, computing the hit, distance, point and face normal.
	function automatic ray_result_t intersect_ray_box(input bit [383:0] item);
		ray_result_t r;
		longint org[3], dir[3], lo[3], hi[3], inv[3], pos[3], ctr[3];
		longint tmin, tmax, t, near_c, far_c, a, b, face, best;
		bit hit;
		int sel;
		tmin = 0;
		tmax = 0;
		best = 0;
		sel = 0;
		hit = 1;
		r = '{default: '0};
		for (int k = 0; k < 3; k++) begin
			org[k] = to_long(item[32*k +: 32]);
			dir[k] = to_long(item[32*(3+k) +: 32]);
			lo[k]  = to_long(item[32*(6+k) +: 32]);
			hi[k]  = to_long(item[32*(9+k) +: 32]);
			// A zero direction counts as positive and saturates high.
			inv[k] = (dir[k] == 0) ? 64'sd2147483647 : clamp32(64'sd4294967296 / dir[k]);
		end
		for (int k = 0; k < 3 && hit; k++) begin
			near_c = (inv[k] < 0) ? hi[k] : lo[k];
			far_c  = (inv[k] < 0) ? lo[k] : hi[k];
			a = clamp32(shr16_floor((near_c - org[k]) * inv[k]));
			b = clamp32(shr16_floor((far_c - org[k]) * inv[k]));
			if (k == 0) begin
				tmin = a;
				tmax = b;
			end else if (tmin > b || a > tmax) begin
				hit = 0;
			end else begin
				if (a > tmin) tmin = a;
				if (b < tmax) tmax = b;
			end
		end
		t = (tmin < rbsi_pkg::T_THRESHOLD) ? tmax : tmin;
		if (!hit || t < rbsi_pkg::T_THRESHOLD) begin
			return r;
		end
		for (int k = 0; k < 3; k++) begin
			pos[k] = clamp32(org[k] + shr16_floor(dir[k] * t));
			ctr[k] = lo[k] + ((hi[k] - lo[k]) >>> 1);
			face = magnitude((hi[k] - ctr[k]) - magnitude(pos[k] - ctr[k]));
			// Smallest face distance wins, lower axis on ties.
			if (k == 0 || face < best) begin
				best = face;
				sel = k;
			end
		end
		r.hit = 1;
		r.hdist = t[31:0];
		for (int k = 0; k < 3; k++) begin
			r.pos[k] = pos[k][31:0];
			if (k == sel) begin
				r.nrm[k] = (pos[k] - ctr[k] < 0) ? rbsi_pkg::NRM_POS : rbsi_pkg::NRM_NEG;
			end else begin
				r.nrm[k] = rbsi_pkg::NRM_ZERO;
			end
		end
		return r;
	endfunction

	function automatic bit [383:0] pack_ray(input bit [2:0][31:0] org, input bit [2:0][31:0] dir,
			input bit [2:0][31:0] lo, input bit [2:0][31:0] hi);
		return {hi, lo, dir, org};
	endfunction

	// Values that stress saturation and rounding.
	function automatic bit [31:0] edge_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'h0000_0001;
			4: return 32'hffff_ffff;
			5: return 32'h0000_0002;
			6: return 32'h0001_0000;
			7: return 32'hffff_0000;
			default: return $urandom;
		endcase
	endfunction

	// Small coordinate in roughly [-64, 64).
	function automatic bit [31:0] small_coord();
		return 32'($signed($urandom_range(0, 32'h007f_ffff)) - 32'sh0040_0000);
	endfunction

	// A ray aimed at a well-formed box most of the time, noise otherwise.
	function automatic bit [383:0] random_ray();
		bit [2:0][31:0] org, dir, lo, hi;
		bit [31:0] c, half;
		int mode;
		mode = $urandom_range(0, 9);
		for (int k = 0; k < 3; k++) begin
			if (mode < 7) begin
				c = small_coord();
				half = $urandom_range(1, 32'h0008_0000);
				lo[k] = c - half;
				hi[k] = c + half;
				org[k] = small_coord();
				// Point roughly toward the box center.
				dir[k] = ($urandom_range(0, 7) == 0) ? 32'h0 :
					(c - org[k]) + 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
			end else if (mode < 9) begin
				lo[k] = edge_value();
				hi[k] = edge_value();
				org[k] = edge_value();
				dir[k] = edge_value();
			end else begin
				lo[k] = $urandom;
				hi[k] = $urandom;
				org[k] = $urandom;
				dir[k] = $urandom;
			end
		end
		return pack_ray(org, dir, lo, hi);
	endfunction

	function automatic ray_result_t unpack_result(input logic [135:0] d);
		ray_result_t r;
		r.hit = d[0];
		r.hdist = d[32:1];
		for (int k = 0; k < 3; k++) begin
			r.pos[k] = d[33 + 32*k +: 32];
			r.nrm[k] = d[129 + 2*k +: 2];
		end
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Directed rays, then random ones through three idling phases.
	initial begin
		bit [2:0][31:0] unit_box_lo, unit_box_hi, zero3;
		arst_n = 1'b0;
		send_idle_pct = 35;
		recv_idle_pct = 55;
		zero3 = '0;
		unit_box_lo = {3{32'hffff_0000}};
		unit_box_hi = {3{32'h0001_0000}};
		// Hits along each axis from both sides.
		for (int k = 0; k < 3; k++) begin
			bit [2:0][31:0] o, d;
			o = '0;
			d = '0;
			o[k] = 32'hfffb_0000;
			d[k] = 32'h0001_0000;
			pending_rays.push_back(pack_ray(o, d, unit_box_lo, unit_box_hi));
			o[k] = 32'h0005_0000;
			d[k] = 32'hffff_0000;
			pending_rays.push_back(pack_ray(o, d, unit_box_lo, unit_box_hi));
		end
		// Origin inside the box: tmin below threshold, tmax used.
		pending_rays.push_back(pack_ray(zero3, {32'h0, 32'h0, 32'h0001_0000},
			unit_box_lo, unit_box_hi));
		// All-zero direction, box behind the ray, inverted box, clear miss.
		pending_rays.push_back(pack_ray(zero3, zero3, unit_box_lo, unit_box_hi));
		pending_rays.push_back(pack_ray({3{32'h0005_0000}}, {3{32'h0001_0000}},
			unit_box_lo, unit_box_hi));
		pending_rays.push_back(pack_ray({3{32'hfffb_0000}}, {3{32'h0001_0000}},
			unit_box_hi, unit_box_lo));
		pending_rays.push_back(pack_ray({32'h0, 32'h0009_0000, 32'hfffb_0000},
			{32'h0, 32'h0, 32'h0001_0000}, unit_box_lo, unit_box_hi));
		// Reciprocal overflow directions of +1, -1 and +2.
		pending_rays.push_back(pack_ray({3{32'hfffb_0000}}, {32'h2, 32'hffff_ffff, 32'h1},
			unit_box_lo, unit_box_hi));
		// Extreme field values.
		pending_rays.push_back({12{32'h7fff_ffff}});
		pending_rays.push_back({12{32'h8000_0000}});
		pending_rays.push_back(pack_ray({3{32'h8000_0000}}, {3{32'h7fff_ffff}},
			{3{32'h8000_0000}}, {3{32'h7fff_ffff}}));
		pending_rays.push_back(pack_ray({3{32'h7fff_ffff}}, {3{32'h8000_0000}},
			{3{32'h8000_0000}}, {3{32'h7fff_ffff}}));
		// Diagonal hit that ties on the face distance.
		pending_rays.push_back(pack_ray({3{32'hfffb_0000}}, {3{32'h0001_0000}},
			unit_box_lo, unit_box_hi));
		pending_rays.push_back({12{32'hffff_ffff}});
		pending_rays.push_back({12{32'h5555_5555}});
		pending_rays.push_back({12{32'haaaa_aaaa}});
		for (int i = 0; i < N_RANDOM / 3; i++) pending_rays.push_back(random_ray());
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_rays.size() == 0);
		send_idle_pct = 55;
		recv_idle_pct = 35;
		for (int i = 0; i < N_RANDOM / 3; i++) pending_rays.push_back(random_ray());
		wait (pending_rays.size() == 0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < N_RANDOM - 2 * (N_RANDOM / 3); i++) begin
			pending_rays.push_back(random_ray());
		end
		wait (pending_rays.size() == 0 && !(s_tvalid && !s_tready));
		@(posedge clk);
		wait (expected_hits.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);
		$display("Checked %0d ray-box results (%0d hits) under three backpressure mixes.",
			results_seen, hits_seen);
		if (error_count == 0 && expected_hits.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Driver: predicts on acceptance, then presents the next ray or idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_hits.push_back(intersect_ray_box(s_tdata));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_rays.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_rays.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		ray_result_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = unpack_result(m_tdata);
				results_seen++;
				if (expected_hits.size() == 0) begin
					$display("%0t: unexpected result %h", $time, m_tdata);
					error_count++;
				end else begin
					want = expected_hits.pop_front();
					hits_seen += want.hit;
					if (got.hit !== want.hit) begin
						$display("%0t: hit_found exp %0d got %0d", $time, want.hit, got.hit);
						error_count++;
					end
					if (got.hdist !== want.hdist) begin
						$display("%0t: hit_dist exp %h got %h", $time, want.hdist, got.hdist);
						error_count++;
					end
					for (int k = 0; k < 3; k++) begin
						if (got.pos[k] !== want.pos[k]) begin
							$display("%0t: hit point axis %0d exp %h got %h", $time, k,
								want.pos[k], got.pos[k]);
							error_count++;
						end
						if (got.nrm[k] !== want.nrm[k]) begin
							$display("%0t: normal axis %0d exp %b got %b", $time, k,
								want.nrm[k], got.nrm[k]);
							error_count++;
						end
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("Run timed out after %0d cycles.", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		cycle_count = 0;
		error_count = 0;
		results_seen = 0;
		hits_seen = 0;
	end

endmodule
